### src/dsda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsda_pkg;

  localparam int unsigned DEF_MAX_YEAR = 2500;
  localparam int unsigned BASE_YEAR    = 1900;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
  localparam logic [2:0] ST_BAD_MONTH = 3'd3;
  localparam logic [2:0] ST_BAD_DAY   = 3'd4;
  localparam logic [2:0] ST_OVERBOUND = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture input, parse and check
    logic ystep;      // add one year length to the last-day bound, and to the running serial below the input year
    logic mstep;      // add one month length
    logic fin_in;     // finish input serial, form shifted serial
    logic ywalk;      // walk years for shifted serial
    logic mwalk;      // walk months for shifted serial
    logic emit;       // build output text
  } dsda_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic [2:0] status;
    logic       year_done;   // year walk has passed MAX_YEAR
    logic       month_done;  // input month reached
    logic       ydone;       // shifted year found
    logic       mdone;       // shifted month found
  } dsda_sts_t;

  // y / 100 by reciprocal multiply, exact for any 14-bit year
  function automatic logic [13:0] div100(input logic [13:0] y);
    logic [27:0] p;
    begin
      p = 28'(y) * 28'd5243;
      div100 = 14'(p >> 19);
    end
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] q;
    logic [6:0]  r;
    begin
      q = div100(y);
      r = 7'(y - 14'(q * 14'd100));
      is_leap = (y[1:0] == 2'd0) && ((r != 7'd0) || (q[1:0] == 2'd0));
    end
  endfunction

  function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
    begin
      case (m)
        4'd2: month_days = is_leap(y) ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
        default: month_days = 5'd31;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

### src/dsda_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dsda_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] date_text;
  logic signed [18:0] day_offset;
  modport source (output valid, date_text, day_offset, input ready);
  modport sink   (input valid, date_text, day_offset, output ready);
endinterface

interface dsda_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [17:0] serial_day;
  logic [2:0]  weekday;
  logic [17:0] shifted_serial;
  logic [63:0] shifted_text;
  modport source (output valid, status, serial_day, weekday, shifted_serial, shifted_text,
                  input ready);
  modport sink   (input valid, status, serial_day, weekday, shifted_serial, shifted_text,
                  output ready);
endinterface
`default_nettype wire

### src/dsda_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dsda_datapath #(
  parameter int unsigned MAX_YEAR = dsda_pkg::DEF_MAX_YEAR
) (
  input  wire                   clk,
  input  wire [63:0]            date_text,
  input  wire signed [18:0]     day_offset,
  input  dsda_pkg::dsda_cmd_t   cmd,
  output dsda_pkg::dsda_sts_t   sts,
  output logic [17:0]           serial_day,
  output logic [2:0]            weekday,
  output logic [17:0]           shifted_serial,
  output logic [63:0]           shifted_text
);
  import dsda_pkg::*;

  localparam logic [13:0] MAXY = 14'(MAX_YEAR);

  logic [2:0]  status;
  logic [13:0] yr, wy;
  logic [3:0]  mo, wm;
  logic [4:0]  dy;
  logic [13:0] cy;   // year counter for input serial
  logic [3:0]  cm;
  logic [21:0] acc;  // running serial of input date
  logic [21:0] sh;   // shifted serial, remaining days during walk
  logic [21:0] lastday;
  logic [21:0] lastsh;
  logic signed [18:0] off;
  logic [2:0]  wdc;  // weekday tracker
  logic [63:0] txt;

  // Parse bytes combinationally at load
  logic [3:0] dg [8];
  logic       badc;
  logic [13:0] py;
  logic [6:0]  pm, pd;
  always_comb begin
    badc = 1'b0;
    for (int i = 0; i < 8; i++) begin
      logic [7:0] c;
      c = date_text[56-8*i +: 8];
      if (c < 8'h30 || c > 8'h39) badc = 1'b1;
      dg[i] = c[3:0];
    end
    py = 14'(dg[0]) * 14'd1000 + 14'(dg[1]) * 14'd100 + 14'(dg[2]) * 14'd10 + 14'(dg[3]);
    pm = 7'(dg[4]) * 7'd10 + 7'(dg[5]);
    pd = 7'(dg[6]) * 7'd10 + 7'(dg[7]);
  end

  logic [8:0] ylen_c, ylen_w;
  assign ylen_c = is_leap(cy) ? 9'd366 : 9'd365;
  assign ylen_w = is_leap(wy) ? 9'd366 : 9'd365;

  // Digit split helpers: two decimal digits of a value below 100
  function automatic logic [15:0] two_dig(input logic [6:0] v);
    logic [3:0] t;
    begin
      t = 4'((15'(v) * 15'd205) >> 11);
      two_dig = {4'h3, t, 4'h3, 4'(v - 7'(t) * 7'd10)};
    end
  endfunction

  // Reduce a value below 42 modulo 7
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = v;
      if (r >= 6'd28) r = r - 6'd28;
      if (r >= 6'd14) r = r - 6'd14;
      if (r >= 6'd7) r = r - 6'd7;
      mod7 = r[2:0];
    end
  endfunction

  logic [13:0] yq;
  logic [6:0]  yhi, ylo;
  assign yq  = div100(wy);
  assign yhi = 7'(yq);
  assign ylo = 7'(wy - 14'(yq * 14'd100));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off <= day_offset;
      yr <= py; mo <= pm[3:0]; dy <= pd[4:0];
      cy <= 14'(BASE_YEAR); cm <= 4'd1; acc <= 22'd0; wdc <= 3'd0;
      lastday <= 22'd0;
      wy <= 14'(BASE_YEAR); wm <= 4'd1; txt <= 64'd0;
      if (badc) status <= ST_BAD_CHAR;
      else if (py < 14'(BASE_YEAR) || py > MAXY) status <= ST_BAD_YEAR;
      else if (pm < 7'd1 || pm > 7'd12) status <= ST_BAD_MONTH;
      else if (pd < 7'd1 || pd > 7'(month_days(py, pm[3:0]))) status <= ST_BAD_DAY;
      else status <= ST_OK;
    end
    // Year walk for input serial and last-day bound, up to MAX_YEAR
    if (cmd.ystep) begin
      if (cy < yr) begin
        acc <= acc + 22'(ylen_c);
        wdc <= mod7(6'(wdc) + ((ylen_c == 9'd366) ? 6'd2 : 6'd1));
      end
      lastday <= lastday + 22'(ylen_c);
      cy <= cy + 14'd1;
    end
    if (cmd.mstep) begin
      acc <= acc + 22'(month_days(yr, cm));
      wdc <= mod7(6'(wdc) + 6'(month_days(yr, cm)) - 6'd28);
      cm <= cm + 4'd1;
    end
    if (cmd.fin_in) begin
      logic [21:0] s;
      logic signed [23:0] t;
      s = acc + 22'(dy);
      acc <= s;
      wdc <= mod7(6'(wdc) + 6'(dy) - 6'd1);
      t = 24'(signed'({2'b0, s})) + 24'(off);
      if (t < 24'sd1 || t > 24'(signed'({2'b0, lastday}))) begin
        status <= ST_OVERBOUND;
        sh <= 22'd0;
      end else sh <= 22'(t);
    end
    if (cmd.ywalk && !sts.ydone) begin
      sh <= sh - 22'(ylen_w);
      wy <= wy + 14'd1;
    end
    if (cmd.mwalk && !sts.mdone) begin
      sh <= sh - 22'(month_days(wy, wm));
      wm <= wm + 4'd1;
    end
    if (cmd.emit) begin
      txt <= {two_dig(yhi), two_dig(ylo), two_dig({3'd0, wm}), two_dig(7'(sh))};
    end
  end

  assign sts.status     = status;
  assign sts.year_done  = (cy > MAXY);
  assign sts.month_done = (cm >= mo);
  assign sts.ydone      = (sh <= 22'(ylen_w)) || (wy >= MAXY);
  assign sts.mdone      = (wm >= 4'd12) || (sh <= 22'(month_days(wy, wm)));

  // Result fields track the state reached by the controller
  logic valid_in;
  assign valid_in       = (status == ST_OK) || (status == ST_OVERBOUND);
  assign serial_day     = valid_in ? acc[17:0] : 18'd0;
  assign weekday        = valid_in ? wdc : 3'd0;
  assign shifted_serial = (status == ST_OK) ? lastsh[17:0] : 18'd0;
  assign shifted_text   = (status == ST_OK) ? txt : 64'd0;

  always_ff @(posedge clk) begin
    if (cmd.fin_in) lastsh <= 22'(24'(signed'({2'b0, acc + 22'(dy)})) + 24'(off));
  end
endmodule
`default_nettype wire

### src/dsda_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dsda_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  dsda_pkg::dsda_sts_t  sts,
  output dsda_pkg::dsda_cmd_t  cmd
);
  import dsda_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_YEAR = 3'd2, S_MON = 3'd3,
                         S_FIN = 3'd4, S_YW = 3'd5, S_MW = 3'd6, S_OUT = 3'd7;
  logic [2:0] state, state_next;
  logic       emit_pending;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT) && !emit_pending;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_CHK; end
      S_CHK: state_next = (sts.status == ST_OK) ? S_YEAR : S_OUT;
      S_YEAR: begin
        cmd.ystep = 1'b1;
        if (sts.year_done) begin cmd.ystep = 1'b0; state_next = S_MON; end
      end
      S_MON: begin
        if (sts.month_done) state_next = S_FIN;
        else cmd.mstep = 1'b1;
      end
      S_FIN: begin cmd.fin_in = 1'b1; state_next = S_YW; end
      S_YW: begin
        if (sts.status != ST_OK) state_next = S_OUT;
        else if (sts.ydone) state_next = S_MW;
        else cmd.ywalk = 1'b1;
      end
      S_MW: begin
        if (sts.mdone) begin cmd.emit = 1'b1; state_next = S_OUT; end
        else cmd.mwalk = 1'b1;
      end
      S_OUT: if (out_ready && !emit_pending) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      emit_pending <= 1'b0;
    end else begin
      state <= state_next;
      emit_pending <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_load_chk: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHK) else $error("load did not start check");
endmodule
`default_nettype wire

### src/date_serial_day_adder.sv
`timescale 1ns / 1ps
`default_nettype none
// date_serial_day_adder: ASCII YYYYMMDD date plus signed day offset.
// Input channel (inp): date_text and day_offset; a transaction is taken
// when valid and ready are high at a rising clk edge.
// Output channel (outp): status, serial_day, weekday, shifted_serial,
// shifted_text, one result transaction per input transaction.
// The time from the input transaction to the result being presented depends
// on MAX_YEAR, the input month and the shifted year and month; an invalid
// date goes to the result straight after the check. For a date that passes
// the check, the year sweep runs over all years up to MAX_YEAR to form the
// upper bound.
// One item is in flight at a time: ready returns the cycle after the result
// is taken, and the next item waits until then.
// rst (synchronous) returns the controller to idle and drops any item.
// If the receiver stalls, the result holds on outp and no new input
// transaction is accepted until it is taken.
module date_serial_day_adder #(
  parameter int unsigned MAX_YEAR = dsda_pkg::DEF_MAX_YEAR
) (
  input wire          clk,
  input wire          rst,
  dsda_in_if.sink     inp,
  dsda_out_if.source  outp
);
  import dsda_pkg::*;

  dsda_cmd_t cmd;
  dsda_sts_t sts;

  dsda_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(inp.valid), .in_ready(inp.ready),
    .out_valid(outp.valid), .out_ready(outp.ready),
    .sts(sts), .cmd(cmd)
  );

  dsda_datapath #(.MAX_YEAR(MAX_YEAR)) u_dp (
    .clk(clk), .date_text(inp.date_text), .day_offset(inp.day_offset),
    .cmd(cmd), .sts(sts),
    .serial_day(outp.serial_day), .weekday(outp.weekday),
    .shifted_serial(outp.shifted_serial), .shifted_text(outp.shifted_text)
  );
  assign outp.status = sts.status;
endmodule
`default_nettype wire
